// ===== rtl/core/tga_psd_pkg.sv =====
// Shared types and constants for the TGA pixel stream decoder.
// No dependencies; imported by tga_psd_pix_fmt and the top level.
package tga_psd_pkg;

	// Result status codes
	localparam logic [1:0] ST_PIXEL     = 2'd0;
	localparam logic [1:0] ST_BAD_TYPE  = 2'd1;
	localparam logic [1:0] ST_BAD_DEPTH = 2'd2;
	localparam logic [1:0] ST_TOO_LARGE = 2'd3;

	// Header layout
	localparam logic [4:0] HDR_ID_LEN    = 5'd0;
	localparam logic [4:0] HDR_MAP_TYPE  = 5'd1;
	localparam logic [4:0] HDR_IMG_TYPE  = 5'd2;
	localparam logic [4:0] HDR_MAP_LEN_L = 5'd5;
	localparam logic [4:0] HDR_MAP_LEN_H = 5'd6;
	localparam logic [4:0] HDR_MAP_BITS  = 5'd7;
	localparam logic [4:0] HDR_WIDTH_L   = 5'd12;
	localparam logic [4:0] HDR_WIDTH_H   = 5'd13;
	localparam logic [4:0] HDR_HEIGHT_L  = 5'd14;
	localparam logic [4:0] HDR_HEIGHT_H  = 5'd15;
	localparam logic [4:0] HDR_DEPTH     = 5'd16;
	localparam logic [4:0] HDR_LAST      = 5'd17;

	localparam logic [7:0] TYPE_TRUECOLOR = 8'd2;
	localparam logic [7:0] DEPTH_16       = 8'd16;
	localparam logic [7:0] DEPTH_24       = 8'd24;
	localparam logic [7:0] DEPTH_32       = 8'd32;

	// Bytes per pixel
	localparam logic [2:0] BPP_2 = 3'd2;
	localparam logic [2:0] BPP_4 = 3'd4;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

	typedef struct packed {
		logic [7:0] c0;
		logic [7:0] c1;
		logic [7:0] c2;
		logic [7:0] c3;
	} chan_t;

endpackage

// ===== rtl/core/tga_psd_pix_fmt.sv =====
// Pixel format expansion: turns the assembled source bytes into four output bytes.
// Depends on tga_psd_pkg.
module tga_psd_pix_fmt
	import tga_psd_pkg::*;
(
	input  logic [2:0] pixel_bytes,
	input  logic [7:0] buf0,
	input  logic [7:0] buf1,
	input  logic [7:0] buf2,
	input  logic [7:0] last_byte,
	output chan_t      chan
);

	logic [15:0] px16;

	assign px16 = {last_byte, buf0};

	always_comb begin
		if (pixel_bytes == BPP_2) begin
			// 5-5-5: widen each field by three low bits, then add 7
			chan.c0 = {px16[4:0], 3'b000} + 8'd7;
			chan.c1 = {px16[9:5], 3'b000} + 8'd7;
			chan.c2 = {px16[14:10], 3'b000} + 8'd7;
			chan.c3 = ALPHA_OPAQUE;
		end else if (pixel_bytes == BPP_4) begin
			chan.c0 = buf0;
			chan.c1 = buf1;
			chan.c2 = buf2;
			chan.c3 = last_byte;
		end else begin
			chan.c0 = buf0;
			chan.c1 = buf1;
			chan.c2 = last_byte;
			chan.c3 = ALPHA_OPAQUE;
		end
	end

endmodule

// ===== rtl/core/tga_pixel_stream_decoder_top.sv =====
// TGA pixel stream decoder: one file byte per request in, zero or one pixel or error
// result per byte out. An accepted byte is loaded into the input register, and its result
// then into the result register once the output slot is free.
// Throughput: one byte per cycle, set by the single-pass control logic between the two
// registers; stalls only on output backpressure. Reset (arst_n low, asynchronous) empties
// both registers and returns the parser to idle, waiting for a byte flagged with file_start.
module tga_pixel_stream_decoder_top
	import tga_psd_pkg::*;
#(
	parameter int MAX_SIDE = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        file_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [25:0] byte_address,
	output logic [7:0]  chan0,
	output logic [7:0]  chan1,
	output logic [7:0]  chan2,
	output logic [7:0]  chan3,
	output logic [1:0]  status,
	output logic        last_pixel
);

	// Parser phases
	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_HEADER = 2'd1;
	localparam logic [1:0] PH_SKIP   = 2'd2;
	localparam logic [1:0] PH_PIXELS = 2'd3;

	localparam logic [15:0] MaxSide = 16'(MAX_SIDE);

	// Input register
	logic       in_valid_s1;
	logic [7:0] data_s1;
	logic       start_s1;

	// Output register
	logic        out_valid_q;
	logic [25:0] addr_q;
	chan_t       chan_q;
	logic [1:0]  status_q;
	logic        last_q;

	// Parser state
	logic [1:0]  phase_q, phase_d;
	logic [4:0]  hdr_cnt_q, hdr_cnt_d;
	logic [7:0]  id_len_q, id_len_d;
	logic [7:0]  map_type_q, map_type_d;
	logic [7:0]  img_type_q, img_type_d;
	logic [15:0] map_len_q, map_len_d;
	logic [7:0]  map_bits_q, map_bits_d;
	logic [15:0] width_q, width_d;
	logic [15:0] height_q, height_d;
	logic [7:0]  depth_q, depth_d;
	logic [21:0] skip_q, skip_d;
	logic [2:0]  pix_bytes_q, pix_bytes_d;
	logic [1:0]  bip_q, bip_d;
	logic [15:0] col_q, col_d;
	logic [15:0] row_q, row_d;
	logic [23:0] base_q, base_d;   // (height-row-1)*width, low 24 bits
	logic [7:0]  buf0_q, buf1_q, buf2_q;

	logic        out_free;
	logic        advance;
	logic [1:0]  eff_phase;
	logic [4:0]  eff_cnt;

	// Header-end arithmetic
	logic [8:0]  entry_sum;
	logic [5:0]  entry_bytes;
	logic [21:0] map_bytes;
	logic [21:0] skip_init;
	logic [23:0] base_prod;

	// Pixel path
	logic        pix_done;
	logic        at_last_col;
	logic        at_last_row;
	logic [23:0] pix_index;
	chan_t       pix_chan;

	// Result of this byte
	logic        res_valid;
	logic [25:0] res_addr;
	chan_t       res_chan;
	logic [1:0]  res_status;
	logic        res_last;

	// Output slot is free when empty or draining this cycle
	assign out_free = !out_valid_q || out_ready;
	assign advance  = in_valid_s1 && out_free;
	assign in_ready = !in_valid_s1 || out_free;

	// A flagged byte restarts the header from byte zero in any phase
	assign eff_phase = start_s1 ? PH_HEADER : phase_q;
	assign eff_cnt   = start_s1 ? 5'd0 : hdr_cnt_q;

	// Skip length: ID field plus, when map type is nonzero, a colour map of length * ceil(bits/8) bytes
	assign entry_sum   = {1'b0, map_bits_q} + 9'd7;
	assign entry_bytes = entry_sum[8:3];
	assign map_bytes   = {6'd0, map_len_q} * {16'd0, entry_bytes};
	assign skip_init   = 22'(id_len_q) + ((map_type_q != 8'd0) ? map_bytes : 22'd0);
	// Row base of the first (bottom-mapped) row
	assign base_prod   = {8'd0, height_q - 16'd1} * {8'd0, width_q};

	assign pix_done    = ({1'b0, bip_q} + 3'd1) == pix_bytes_q;
	assign at_last_col = col_q == (width_q - 16'd1);
	assign at_last_row = row_q == (height_q - 16'd1);
	assign pix_index   = base_q + 24'(col_q);

	tga_psd_pix_fmt u_pix_fmt (
		.pixel_bytes (pix_bytes_q),
		.buf0        (buf0_q),
		.buf1        (buf1_q),
		.buf2        (buf2_q),
		.last_byte   (data_s1),
		.chan        (pix_chan)
	);

	always_comb begin
		phase_d     = eff_phase;
		hdr_cnt_d   = eff_cnt;
		id_len_d    = id_len_q;
		map_type_d  = map_type_q;
		img_type_d  = img_type_q;
		map_len_d   = map_len_q;
		map_bits_d  = map_bits_q;
		width_d     = width_q;
		height_d    = height_q;
		depth_d     = depth_q;
		skip_d      = skip_q;
		pix_bytes_d = pix_bytes_q;
		bip_d       = bip_q;
		col_d       = col_q;
		row_d       = row_q;
		base_d      = base_q;
		res_valid   = 1'b0;
		res_addr    = '0;
		res_chan    = '0;
		res_status  = ST_PIXEL;
		res_last    = 1'b0;

		unique case (eff_phase)
			PH_HEADER: begin
				hdr_cnt_d = eff_cnt + 5'd1;
				case (eff_cnt)
					HDR_ID_LEN:    id_len_d = data_s1;
					HDR_MAP_TYPE:  map_type_d = data_s1;
					HDR_IMG_TYPE:  img_type_d = data_s1;
					HDR_MAP_LEN_L: map_len_d[7:0] = data_s1;
					HDR_MAP_LEN_H: map_len_d[15:8] = data_s1;
					HDR_MAP_BITS:  map_bits_d = data_s1;
					HDR_WIDTH_L:   width_d[7:0] = data_s1;
					HDR_WIDTH_H:   width_d[15:8] = data_s1;
					HDR_HEIGHT_L:  height_d[7:0] = data_s1;
					HDR_HEIGHT_H:  height_d[15:8] = data_s1;
					HDR_DEPTH:     depth_d = data_s1;
					default: ;
				endcase
				// Last header byte carries nothing; all fields are already registered
				if (eff_cnt == HDR_LAST) begin
					phase_d = PH_IDLE;
					if (img_type_q != TYPE_TRUECOLOR) begin
						res_valid  = 1'b1;
						res_status = ST_BAD_TYPE;
					end else if (depth_q != DEPTH_16 && depth_q != DEPTH_24 &&
							depth_q != DEPTH_32) begin
						res_valid  = 1'b1;
						res_status = ST_BAD_DEPTH;
					end else if (width_q > MaxSide || height_q > MaxSide) begin
						res_valid  = 1'b1;
						res_status = ST_TOO_LARGE;
					end else if (width_q != 16'd0 && height_q != 16'd0) begin
						pix_bytes_d = depth_q[5:3];
						col_d       = '0;
						row_d       = '0;
						bip_d       = '0;
						base_d      = base_prod;
						skip_d      = skip_init;
						phase_d     = (skip_init != 22'd0) ? PH_SKIP : PH_PIXELS;
					end
				end
			end
			PH_SKIP: begin
				skip_d = skip_q - 22'd1;
				if (skip_q == 22'd1) begin
					phase_d = PH_PIXELS;
				end
			end
			PH_PIXELS: begin
				if (!pix_done) begin
					bip_d = bip_q + 2'd1;
				end else begin
					bip_d      = '0;
					res_valid  = 1'b1;
					res_chan   = pix_chan;
					res_addr   = {pix_index, 2'b00};
					res_last   = at_last_row && at_last_col;
					if (at_last_row && at_last_col) begin
						phase_d = PH_IDLE;
					end else if (at_last_col) begin
						col_d  = '0;
						row_d  = row_q + 16'd1;
						base_d = base_q - 24'(width_q);
					end else begin
						col_d = col_q + 16'd1;
					end
				end
			end
			default: ;   // idle: drop unflagged bytes
		endcase
	end

	// Input register: hold a request until the core can take it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1  <= data_byte;
			start_s1 <= file_start;
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			hdr_cnt_q   <= '0;
			id_len_q    <= '0;
			map_type_q  <= '0;
			img_type_q  <= '0;
			map_len_q   <= '0;
			map_bits_q  <= '0;
			width_q     <= '0;
			height_q    <= '0;
			depth_q     <= '0;
			skip_q      <= '0;
			pix_bytes_q <= '0;
			bip_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
			base_q      <= '0;
		end else if (advance) begin
			phase_q     <= phase_d;
			hdr_cnt_q   <= hdr_cnt_d;
			id_len_q    <= id_len_d;
			map_type_q  <= map_type_d;
			img_type_q  <= img_type_d;
			map_len_q   <= map_len_d;
			map_bits_q  <= map_bits_d;
			width_q     <= width_d;
			height_q    <= height_d;
			depth_q     <= depth_d;
			skip_q      <= skip_d;
			pix_bytes_q <= pix_bytes_d;
			bip_q       <= bip_d;
			col_q       <= col_d;
			row_q       <= row_d;
			base_q      <= base_d;
		end
	end

	// Pixel assembly buffer; the final byte of a pixel is used straight from the input
	always_ff @(posedge clk) begin
		if (advance && eff_phase == PH_PIXELS && !pix_done) begin
			case (bip_q)
				2'd0:    buf0_q <= data_s1;
				2'd1:    buf1_q <= data_s1;
				default: buf2_q <= data_s1;
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			addr_q   <= res_addr;
			chan_q   <= res_chan;
			status_q <= res_status;
			last_q   <= res_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign byte_address = addr_q;
	assign chan0        = chan_q.c0;
	assign chan1        = chan_q.c1;
	assign chan2        = chan_q.c2;
	assign chan3        = chan_q.c3;
	assign status       = status_q;
	assign last_pixel   = last_q;

endmodule
